### hdl/arq_pkg.sv
// Shared types, widths, command codes and the product term table
// for the arcball rotation unit. No dependencies.
`default_nettype none

package arq_pkg;

	// Fixed-point format and field widths.
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 14;
	localparam int OUT_FRAC   = 14;
	localparam int SIZE_W     = 13;
	localparam int OUT_W      = 16;

	// Working widths.
	localparam int XW       = COORD_BITS + FRAC_BITS + 4;  // mapped coordinate
	localparam int SMALL_W  = FRAC_BITS + 3;               // after range reduction
	localparam int R2_W     = 2 * SMALL_W - 1;             // sum of squares
	localparam int COMP_W   = FRAC_BITS + 2;               // sphere component
	localparam int PROD_W   = 2 * COMP_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int RSH      = 2 * FRAC_BITS - OUT_FRAC;
	localparam int Q_W      = ACC_W - RSH;
	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = SMALL_W;
	localparam int SQ_IN_W  = 2 * SMALL_W;
	localparam int ROOT_W   = SMALL_W;

	// Datapath commands.
	localparam logic [4:0] CMD_NONE     = 5'd0;
	localparam logic [4:0] CMD_LOAD     = 5'd1;
	localparam logic [4:0] CMD_DIV_X    = 5'd2;
	localparam logic [4:0] CMD_TAKE_X   = 5'd3;
	localparam logic [4:0] CMD_DIV_Y    = 5'd4;
	localparam logic [4:0] CMD_TAKE_Y   = 5'd5;
	localparam logic [4:0] CMD_HALVE    = 5'd6;
	localparam logic [4:0] CMD_SQ_X     = 5'd7;
	localparam logic [4:0] CMD_SQ_Y     = 5'd8;
	localparam logic [4:0] CMD_SQRT_R   = 5'd9;
	localparam logic [4:0] CMD_SQRT_Z   = 5'd10;
	localparam logic [4:0] CMD_TAKE_LEN = 5'd11;
	localparam logic [4:0] CMD_TAKE_Z   = 5'd12;
	localparam logic [4:0] CMD_DIV_NX   = 5'd13;
	localparam logic [4:0] CMD_TAKE_NX  = 5'd14;
	localparam logic [4:0] CMD_DIV_NY   = 5'd15;
	localparam logic [4:0] CMD_TAKE_NY  = 5'd16;
	localparam logic [4:0] CMD_STORE    = 5'd17;
	localparam logic [4:0] CMD_MUL      = 5'd18;
	localparam logic [4:0] CMD_ACC      = 5'd19;
	localparam logic [4:0] CMD_ROUND    = 5'd20;
	localparam logic [4:0] CMD_EMIT     = 5'd21;

	// Configuration register indexes.
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	localparam logic [3:0] LAST_TERM = 4'd8;

	typedef struct packed {
		logic [4:0] code;
		logic [3:0] term;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic big;
		logic outside;
		logic drag;
	} status_t;

	// Term table: q[comp] is built from products click[c] * drag[d].
	function automatic logic [1:0] term_c(input logic [3:0] t);
		case (t)
			4'd0, 4'd5, 4'd7: term_c = 2'd1;
			4'd1, 4'd2, 4'd8: term_c = 2'd2;
			default:          term_c = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] term_d(input logic [3:0] t);
		case (t)
			4'd0, 4'd3, 4'd8: term_d = 2'd2;
			4'd1, 4'd4, 4'd7: term_d = 2'd1;
			default:          term_d = 2'd0;
		endcase
	endfunction

	function automatic logic term_neg(input logic [3:0] t);
		term_neg = (t == 4'd1) || (t == 4'd3) || (t == 4'd5);
	endfunction

	function automatic logic term_first(input logic [3:0] t);
		term_first = (t == 4'd0) || (t == 4'd2) || (t == 4'd4) || (t == 4'd6);
	endfunction

	function automatic logic term_last(input logic [3:0] t);
		term_last = (t == 4'd1) || (t == 4'd3) || (t == 4'd5) || (t == 4'd8);
	endfunction

	function automatic logic [1:0] term_comp(input logic [3:0] t);
		case (t)
			4'd0, 4'd1: term_comp = 2'd0;
			4'd2, 4'd3: term_comp = 2'd1;
			4'd4, 4'd5: term_comp = 2'd2;
			default:    term_comp = 2'd3;
		endcase
	endfunction

endpackage

`default_nettype wire

### hdl/arcball_rotation_quaternion_unit.sv
// Arcball rotation unit: a click stores a sphere point, a drag gives one
// quaternion item (click x drag, click . drag) in signed Q2.14.
// One item at a time. An item may take up to eleven halving steps; a point inside the
// disc then makes two passes through the shared divider and one through the root unit,
// one outside it four divider passes and one root pass; a drag adds the product terms.
// Reset (arst_n low, asynchronous) sets 1024 x 768 and a zero click point.
`default_nettype none

module arcball_rotation_quaternion_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [12:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // x_pos[11:0], y_pos[23:12]
	input  wire logic [0:0]  s_tuser,   // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata    // rot_x, rot_y, rot_z, rot_w (16 bits each)
);
	import arq_pkg::*;

	cmd_t    cmd;
	status_t status;

	arq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	arq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_op     (s_tuser[0]),
		.in_x      (s_tdata[11:0]),
		.in_y      (s_tdata[23:12]),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

### hdl/arq_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on arq_pkg for its widths.
`default_nettype none

module arq_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [arq_pkg::DIV_NUM_W-1:0]  num,
	input  wire logic [arq_pkg::DIV_DEN_W-1:0]  den,
	output logic                                busy,
	output logic [arq_pkg::DIV_NUM_W-1:0]       quot
);
	import arq_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// Partial remainder with the next numerator bit shifted in.
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DIV_DEN_W-1:0];
			end
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

### hdl/arq_sqrt.sv
// Digit-by-digit integer floor square root, one root bit per cycle.
// Depends on arq_pkg for its widths.
`default_nettype none

module arq_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [arq_pkg::SQ_IN_W-1:0]  val,
	output logic                              busy,
	output logic [arq_pkg::ROOT_W-1:0]        root
);
	import arq_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);

	logic [SQ_IN_W-1:0] val_q;
	logic [ROOT_W+1:0]  rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [ROOT_W+2:0]  cand;
	logic [ROOT_W+2:0]  trial;
	logic               fits;

	assign cand  = {rem_q[ROOT_W:0], val_q[SQ_IN_W-1:SQ_IN_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = cand >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Two radicand bits enter per step; the root grows by one bit.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[SQ_IN_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= (ROOT_W + 2)'(cand - trial);
			end else begin
				rem_q <= cand[ROOT_W+1:0];
			end
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

### hdl/arq_datapath.sv
// Datapath: configuration, screen mapping, sphere lift, product accumulation
// and result registers. Depends on arq_pkg, arq_div and arq_sqrt.
`default_nettype none

module arq_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [0:0]                  cfg_addr,
	input  wire logic [arq_pkg::SIZE_W-1:0]  cfg_wdata,
	input  wire logic                        in_op,
	input  wire logic [arq_pkg::COORD_BITS-1:0] in_x,
	input  wire logic [arq_pkg::COORD_BITS-1:0] in_y,
	input  wire arq_pkg::cmd_t               cmd,
	output arq_pkg::status_t                 status,
	output logic [4*arq_pkg::OUT_W-1:0]      out_data
);
	import arq_pkg::*;

	localparam logic signed [XW-1:0] ONE = XW'(1) <<< FRAC_BITS;
	localparam logic signed [XW-1:0] LIM = XW'(4) <<< FRAC_BITS;
	localparam logic [R2_W-1:0] ONE2 = R2_W'(1) << (2 * FRAC_BITS);

	logic [SIZE_W-1:0]       width_q, height_q;
	logic                    op_q;
	logic [COORD_BITS-1:0]   xp_q, yp_q;
	logic signed [XW-1:0]    x_q, y_q;
	logic [R2_W-1:0]         sqx_q, r2_q;
	logic [ROOT_W-1:0]       len_q;
	logic signed [COMP_W-1:0] p_q [3];
	logic signed [COMP_W-1:0] click_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [Q_W-1:0]    rq_q [4];
	logic [4*OUT_W-1:0]      out_q;

	logic [SIZE_W-1:0]       den_w, den_h;
	logic                    div_start, sqrt_start;
	logic [DIV_NUM_W-1:0]    div_num, div_quot;
	logic [DIV_DEN_W-1:0]    div_den;
	logic [SQ_IN_W-1:0]      sqrt_val;
	logic [ROOT_W-1:0]       sqrt_root;
	logic                    div_busy, sqrt_busy;
	logic signed [SMALL_W-1:0] xs, ys;
	logic [SMALL_W-2:0]      ax, ay;
	logic signed [XW-1:0]    quot_s;
	logic signed [COMP_W-1:0] quot_c;
	logic signed [ACC_W-1:0]  prod_x, acc_rnd;
	logic                    rot_zero;

	function automatic logic [SIZE_W-1:0] den_of(input logic [SIZE_W-1:0] size);
		den_of = (size < SIZE_W'(2)) ? SIZE_W'(1) : SIZE_W'(size - 1'b1);
	endfunction

	function automatic logic [OUT_W-1:0] sat(input logic signed [Q_W-1:0] v);
		if (v > Q_W'(32767)) begin
			sat = 16'h7FFF;
		end else if (v < -Q_W'(32768)) begin
			sat = 16'h8000;
		end else begin
			sat = v[OUT_W-1:0];
		end
	endfunction

	assign den_w  = den_of(width_q);
	assign den_h  = den_of(height_q);
	assign xs     = x_q[SMALL_W-1:0];
	assign ys     = y_q[SMALL_W-1:0];
	assign ax     = x_q[XW-1] ? (SMALL_W - 1)'(-x_q) : x_q[SMALL_W-2:0];
	assign ay     = y_q[XW-1] ? (SMALL_W - 1)'(-y_q) : y_q[SMALL_W-2:0];
	assign quot_s = $signed({2'b00, div_quot[XW-3:0]});
	assign quot_c = div_quot[COMP_W-1:0];
	assign prod_x = ACC_W'(prod_q);
	assign acc_rnd = acc_q + (ACC_W'(1) <<< (RSH - 1));

	// Operand selection for the shared divider and root unit.
	always_comb begin
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		div_num    = '0;
		div_den    = DIV_DEN_W'(1);
		sqrt_val   = '0;
		case (cmd.code)
			CMD_DIV_X: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({xp_q, {(FRAC_BITS + 1){1'b0}}})
				          + DIV_NUM_W'(den_w >> 1);
				div_den   = DIV_DEN_W'(den_w);
			end
			CMD_DIV_Y: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({yp_q, {(FRAC_BITS + 1){1'b0}}})
				          + DIV_NUM_W'(den_h >> 1);
				div_den   = DIV_DEN_W'(den_h);
			end
			CMD_DIV_NX: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({ax, {FRAC_BITS{1'b0}}}) + DIV_NUM_W'(len_q >> 1);
				div_den   = len_q;
			end
			CMD_DIV_NY: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({ay, {FRAC_BITS{1'b0}}}) + DIV_NUM_W'(len_q >> 1);
				div_den   = len_q;
			end
			CMD_SQRT_R: begin
				sqrt_start = 1'b1;
				sqrt_val   = SQ_IN_W'(r2_q);
			end
			CMD_SQRT_Z: begin
				sqrt_start = 1'b1;
				sqrt_val   = SQ_IN_W'(ONE2 - r2_q);
			end
			default: begin
			end
		endcase
	end

	arq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	arq_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.val    (sqrt_val),
		.busy   (sqrt_busy),
		.root   (sqrt_root)
	);

	// Configuration and the stored click point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1024);
			height_q <= SIZE_W'(768);
			for (int i = 0; i < 3; i++) begin
				click_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					REG_WIDTH:  width_q  <= cfg_wdata;
					REG_HEIGHT: height_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (cmd.code == CMD_STORE) begin
				for (int i = 0; i < 3; i++) begin
					click_q[i] <= p_q[i];
				end
			end
		end
	end

	// Working registers, advanced by the controller's commands.
	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LOAD: begin
				op_q <= in_op;
				xp_q <= in_x;
				yp_q <= in_y;
			end
			CMD_TAKE_X: x_q <= quot_s - ONE;
			CMD_TAKE_Y: y_q <= ONE - quot_s;
			CMD_HALVE: begin
				// Halving truncates toward zero, so negative values are biased by one.
				x_q <= (x_q + $signed(XW'(x_q[XW-1]))) >>> 1;
				y_q <= (y_q + $signed(XW'(y_q[XW-1]))) >>> 1;
			end
			CMD_SQ_X: sqx_q <= R2_W'(xs * xs);
			CMD_SQ_Y: r2_q  <= sqx_q + R2_W'(ys * ys);
			CMD_TAKE_LEN: len_q <= sqrt_root;
			CMD_TAKE_Z: begin
				p_q[0] <= x_q[COMP_W-1:0];
				p_q[1] <= y_q[COMP_W-1:0];
				p_q[2] <= -$signed(COMP_W'(sqrt_root));
			end
			CMD_TAKE_NX: begin
				p_q[0] <= x_q[XW-1] ? -quot_c : quot_c;
				p_q[2] <= '0;
			end
			CMD_TAKE_NY: p_q[1] <= y_q[XW-1] ? -quot_c : quot_c;
			CMD_MUL: prod_q <= click_q[term_c(cmd.term)] * p_q[term_d(cmd.term)];
			CMD_ACC: begin
				if (term_first(cmd.term)) begin
					acc_q <= term_neg(cmd.term) ? -prod_x : prod_x;
				end else begin
					acc_q <= term_neg(cmd.term) ? acc_q - prod_x : acc_q + prod_x;
				end
			end
			CMD_ROUND: rq_q[term_comp(cmd.term)] <= acc_rnd[ACC_W-1:RSH];
			CMD_EMIT: begin
				out_q <= rot_zero ? '0
				       : {sat(rq_q[3]), sat(rq_q[2]), sat(rq_q[1]), sat(rq_q[0])};
			end
			default: begin
			end
		endcase
	end

	// A cross vector that rounds to zero gives an all-zero rotation.
	assign rot_zero = (rq_q[0] == '0) && (rq_q[1] == '0) && (rq_q[2] == '0);

	assign status.div_busy  = div_busy;
	assign status.sqrt_busy = sqrt_busy;
	assign status.big       = (x_q >= LIM) || (x_q <= -LIM) || (y_q >= LIM) || (y_q <= -LIM);
	assign status.outside   = r2_q > ONE2;
	assign status.drag      = op_q;
	assign out_data         = out_q;

endmodule

`default_nettype wire

### hdl/arq_ctrl.sv
// Controller state machine: sequences the datapath through one item and
// owns both handshakes. Depends on arq_pkg.
`default_nettype none

module arq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire arq_pkg::status_t  status,
	output arq_pkg::cmd_t          cmd
);
	import arq_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DIVX = 5'd1;
	localparam logic [4:0] S_WX   = 5'd2;
	localparam logic [4:0] S_DIVY = 5'd3;
	localparam logic [4:0] S_WY   = 5'd4;
	localparam logic [4:0] S_HALV = 5'd5;
	localparam logic [4:0] S_SQY  = 5'd6;
	localparam logic [4:0] S_SQRT = 5'd7;
	localparam logic [4:0] S_WSQ  = 5'd8;
	localparam logic [4:0] S_NX   = 5'd9;
	localparam logic [4:0] S_WNX  = 5'd10;
	localparam logic [4:0] S_NY   = 5'd11;
	localparam logic [4:0] S_WNY  = 5'd12;
	localparam logic [4:0] S_PT   = 5'd13;
	localparam logic [4:0] S_MUL  = 5'd14;
	localparam logic [4:0] S_ACC  = 5'd15;
	localparam logic [4:0] S_RND  = 5'd16;
	localparam logic [4:0] S_EMIT = 5'd17;

	logic [4:0] state_q, state_d;
	logic [3:0] term_q, term_d;
	logic       ovalid_q;
	logic       emit;

	always_comb begin
		state_d  = state_q;
		term_d   = term_q;
		cmd.code = CMD_NONE;
		cmd.term = term_q;
		emit     = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.code = CMD_LOAD;
				state_d  = S_DIVX;
			end
			S_DIVX: begin
				cmd.code = CMD_DIV_X;
				state_d  = S_WX;
			end
			S_WX: if (!status.div_busy) begin
				cmd.code = CMD_TAKE_X;
				state_d  = S_DIVY;
			end
			S_DIVY: begin
				cmd.code = CMD_DIV_Y;
				state_d  = S_WY;
			end
			S_WY: if (!status.div_busy) begin
				cmd.code = CMD_TAKE_Y;
				state_d  = S_HALV;
			end
			S_HALV: begin
				if (status.big) begin
					cmd.code = CMD_HALVE;
				end else begin
					cmd.code = CMD_SQ_X;
					state_d  = S_SQY;
				end
			end
			S_SQY: begin
				cmd.code = CMD_SQ_Y;
				state_d  = S_SQRT;
			end
			S_SQRT: begin
				cmd.code = status.outside ? CMD_SQRT_R : CMD_SQRT_Z;
				state_d  = S_WSQ;
			end
			S_WSQ: if (!status.sqrt_busy) begin
				if (status.outside) begin
					cmd.code = CMD_TAKE_LEN;
					state_d  = S_NX;
				end else begin
					cmd.code = CMD_TAKE_Z;
					state_d  = S_PT;
				end
			end
			S_NX: begin
				cmd.code = CMD_DIV_NX;
				state_d  = S_WNX;
			end
			S_WNX: if (!status.div_busy) begin
				cmd.code = CMD_TAKE_NX;
				state_d  = S_NY;
			end
			S_NY: begin
				cmd.code = CMD_DIV_NY;
				state_d  = S_WNY;
			end
			S_WNY: if (!status.div_busy) begin
				cmd.code = CMD_TAKE_NY;
				state_d  = S_PT;
			end
			S_PT: begin
				if (status.drag) begin
					term_d  = '0;
					state_d = S_MUL;
				end else begin
					cmd.code = CMD_STORE;
					state_d  = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.code = CMD_MUL;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.code = CMD_ACC;
				if (term_last(term_q)) begin
					state_d = S_RND;
				end else begin
					term_d  = term_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_RND: begin
				cmd.code = CMD_ROUND;
				if (term_q == LAST_TERM) begin
					state_d = S_EMIT;
				end else begin
					term_d  = term_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_EMIT: if (!ovalid_q || out_ready) begin
				cmd.code = CMD_EMIT;
				emit     = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			term_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;

endmodule

`default_nettype wire

### tb/tb_arcball_rotation_quaternion_unit.sv
// Self-checking testbench for the arcball rotation unit: drives click and drag items,
// predicts each quaternion in fixed point and compares it with the block's output.
// Depends on arq_pkg and arcball_rotation_quaternion_unit.
`default_nettype none

module tb_arcball_rotation_quaternion_unit;
	import arq_pkg::*;

	localparam logic OP_CLICK = 1'b0;
	localparam logic OP_DRAG  = 1'b1;
	localparam int   STALL_LIMIT = 20000;

	typedef struct packed {
		logic signed [15:0] rw;
		logic signed [15:0] rz;
		logic signed [15:0] ry;
		logic signed [15:0] rx;
	} quat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_addr = '0;
	logic [12:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;

	// Predictor state.
	longint unsigned view_w = 1024, view_h = 768;
	longint click_pt [3] = '{0, 0, 0};
	quat_t  pending_quats [$];
	int     mismatches = 0;
	int     stall_cycles = 0;
	bit     rx_idle_enable = 1'b1;

	arcball_rotation_quaternion_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Rounds half towards plus infinity while dropping s fraction bits.
	function automatic longint round_drop(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic longint pixel_to_unit(longint unsigned pos, longint unsigned size);
		longint unsigned den;
		if (size < 2) size = 2;
		den = size - 1;
		pos &= (64'd1 << COORD_BITS) - 1;
		return longint'((((pos << FRAC_BITS) << 1) + den / 2) / den);
	endfunction

	function automatic longint rim_div(longint c, longint unsigned len);
		longint unsigned mag;
		mag = c < 0 ? longint'(-c) : c;
		mag = ((mag << FRAC_BITS) + len / 2) / len;
		return c < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	// Lifts a pixel position onto the unit sphere.
	task automatic lift_to_sphere(input longint unsigned xp, input longint unsigned yp,
			output longint p [3]);
		longint x, y, one, lim;
		longint unsigned r2, len;
		one = 64'sd1 <<< FRAC_BITS;
		lim = 4 * one;
		x = pixel_to_unit(xp, view_w) - one;
		y = one - pixel_to_unit(yp, view_h);
		while (x >= lim || x <= -lim || y >= lim || y <= -lim) begin
			x = x / 2;
			y = y / 2;
		end
		r2 = x * x + y * y;
		if (r2 > one * one) begin
			len = isqrt(r2);
			p[0] = rim_div(x, len);
			p[1] = rim_div(y, len);
			p[2] = 0;
		end else begin
			p[0] = x;
			p[1] = y;
			p[2] = -longint'(isqrt(one * one - r2));
		end
	endtask

	task automatic predict_rotation(input logic op, input logic [11:0] xp, input logic [11:0] yp);
		longint d [3];
		longint q [4];
		quat_t  res;
		int     s;
		s = 2 * FRAC_BITS - OUT_FRAC;
		if (op == OP_CLICK) begin
			lift_to_sphere(xp, yp, click_pt);
		end else begin
			lift_to_sphere(xp, yp, d);
			q[0] = round_drop(click_pt[1] * d[2] - click_pt[2] * d[1], s);
			q[1] = round_drop(click_pt[2] * d[0] - click_pt[0] * d[2], s);
			q[2] = round_drop(click_pt[0] * d[1] - click_pt[1] * d[0], s);
			q[3] = round_drop(click_pt[0] * d[0] + click_pt[1] * d[1] + click_pt[2] * d[2], s);
			if (q[0] == 0 && q[1] == 0 && q[2] == 0) q[3] = 0;
			res.rx = clamp16(q[0]);
			res.ry = clamp16(q[1]);
			res.rz = clamp16(q[2]);
			res.rw = clamp16(q[3]);
			pending_quats.push_back(res);
		end
	endtask

	// Sends one item after a random gap and records its expected result.
	// The valid line stays high after acceptance until the next call or an idle phase.
	task automatic send_event(input logic op, input logic [11:0] xp, input logic [11:0] yp);
		int gap;
		gap = (op == OP_DRAG && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if ($urandom_range(0, 4) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {yp, xp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_rotation(op, xp, yp);
		@(negedge clk);
	endtask

	// Waits for the block to drain, then writes one register.
	task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
		s_tvalid <= 1'b0;
		while (pending_quats.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_WIDTH) view_w = val;
		else view_h = val;
	endtask

	task automatic test_directed();
		send_event(OP_DRAG, 12'd512, 12'd384);   // drag before any click
		send_event(OP_CLICK, 12'd512, 12'd384);
		send_event(OP_DRAG, 12'd512, 12'd384);   // no rotation at all
		send_event(OP_DRAG, 12'd0, 12'd0);
		send_event(OP_DRAG, 12'd1023, 12'd767);
		send_event(OP_DRAG, 12'd4095, 12'd4095); // far outside the disc
		send_event(OP_CLICK, 12'd0, 12'd4095);
		send_event(OP_DRAG, 12'd4095, 12'd0);
		send_event(OP_DRAG, 12'd700, 12'd300);
		send_event(OP_CLICK, 12'd600, 12'd400);
		send_event(OP_DRAG, 12'd601, 12'd400);   // tiny move
		send_event(OP_DRAG, 12'd2730, 12'd1365);
	endtask

	// Drags near the click point dominate, with jumps anywhere in the coordinate space.
	task automatic test_random(input int count, input int span);
		logic [11:0] cx, cy, xp, yp;
		cx = 12'($urandom_range(0, span));
		cy = 12'($urandom_range(0, span));
		send_event(OP_CLICK, cx, cy);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				cx = $urandom_range(0, 7) == 0 ? 12'($urandom) : 12'($urandom_range(0, span));
				cy = $urandom_range(0, 7) == 0 ? 12'($urandom) : 12'($urandom_range(0, span));
				send_event(OP_CLICK, cx, cy);
			end else begin
				if ($urandom_range(0, 5) == 0) begin
					xp = 12'($urandom);
					yp = 12'($urandom);
				end else begin
					xp = 12'(int'(cx) + $urandom_range(0, 60) - 30);
					yp = 12'(int'(cy) + $urandom_range(0, 60) - 30);
				end
				send_event(OP_DRAG, xp, yp);
			end
		end
	endtask

	task automatic test_sizes();
		write_reg(REG_WIDTH, 13'd2);
		write_reg(REG_HEIGHT, 13'd2);
		test_random(40, 3);
		write_reg(REG_WIDTH, 13'd0);              // size below two acts as two
		write_reg(REG_HEIGHT, 13'd1);
		test_random(40, 3);
		write_reg(REG_WIDTH, 13'd4096);
		write_reg(REG_HEIGHT, 13'd4096);
		test_random(200, 4095);
		write_reg(REG_WIDTH, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'd37);
		test_random(150, 4095);
		write_reg(REG_WIDTH, 13'd640);
		write_reg(REG_HEIGHT, 13'd480);
		test_random(300, 700);
	endtask

	// Result checker with random back-pressure.
	always @(posedge clk) begin
		quat_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_quats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h", m_tdata);
			end else begin
				want = pending_quats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected x %0d y %0d z %0d w %0d, got x %0d y %0d z %0d w %0d",
							want.rx, want.ry, want.rz, want.rw, got.rx, got.ry, got.rz, got.rw);
				end
			end
		end
	end

	// Ready rises after a random wait, zero in the no-idle phase; it drops after each transfer.
	always @(negedge clk) begin
		int wait_cycles;
		if (m_tvalid && !m_tready) begin
			wait_cycles = rx_idle_enable ? $urandom_range(0, 11) : 0;
			repeat (wait_cycles) @(negedge clk);
			m_tready <= 1'b1;
		end else if (m_tready) begin
			m_tready <= 1'b0;
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			stall_cycles <= 0;
		else if (arst_n)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(450, 1023);
		rx_idle_enable = 1'b0;
		test_random(100, 1023);
		rx_idle_enable = 1'b1;
		test_sizes();
		s_tvalid <= 1'b0;
		while (pending_quats.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0 && pending_quats.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/arq_pkg.sv
hdl/arq_div.sv
hdl/arq_sqrt.sv
hdl/arq_datapath.sv
hdl/arq_ctrl.sv
hdl/arcball_rotation_quaternion_unit.sv
tb/tb_arcball_rotation_quaternion_unit.sv
